FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the address text block.
// Holds macro definitions only; the including file supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ia2t_pkg.sv
// Shared types and constants of the address-to-text block.
// Used by the digit unit, the zero-run scanner, the top level and its checker.
package ia2t_pkg;

  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SMALL  = 2'd1;
  localparam logic [1:0] ST_FAMILY = 2'd2;

  localparam logic [7:0] IPV4_MIN_BUF = 8'd16;
  localparam logic [7:0] IPV6_MIN_BUF = 8'd46;

  localparam logic [6:0] CH_COLON = 7'h3a;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_HEXA  = 7'h57;  // 'a' minus ten
  localparam logic [6:0] CH_NONE  = 7'h00;

  // Longest run of zero words found so far.
  typedef struct packed {
    logic       has_run;
    logic [2:0] start;
    logic [3:0] len;
  } zrun_t;

endpackage

FILE: hdl/ia2t_digit_unit.sv
// Shared digit unit: one hex or decimal character per cycle, plus the
// leading-digit position of a word about to be printed. Uses ia2t_pkg.
module ia2t_digit_unit (
  input  logic        is_hex,
  input  logic [15:0] load_word,
  input  logic [15:0] word,
  input  logic [1:0]  dpos,
  output logic [6:0]  ch,
  output logic [1:0]  lead
);
  import ia2t_pkg::*;

  logic [3:0] nib;
  logic [1:0] hund;
  logic [6:0] rem100;
  logic [3:0] tens;
  logic [6:0] ones;

  always_comb begin
    nib = word[{dpos, 2'b00} +: 4];
    if (word[7:0] >= 8'd200) begin
      hund = 2'd2;
    end else if (word[7:0] >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem100 = 7'(word[7:0] - 8'(hund) * 8'd100);
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem100 >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    ones = 7'(rem100 - 7'(tens) * 7'd10);

    if (is_hex) begin
      ch = (nib < 4'd10) ? CH_ZERO + 7'(nib) : CH_HEXA + 7'(nib);
    end else begin
      unique case (dpos)
        2'd2:    ch = CH_ZERO + 7'(hund);
        2'd1:    ch = CH_ZERO + 7'(tens);
        default: ch = CH_ZERO + ones;
      endcase
    end

    if (is_hex) begin
      if (load_word[15:12] != 4'd0) begin
        lead = 2'd3;
      end else if (load_word[11:8] != 4'd0) begin
        lead = 2'd2;
      end else if (load_word[7:4] != 4'd0) begin
        lead = 2'd1;
      end else begin
        lead = 2'd0;
      end
    end else begin
      if (load_word[7:0] >= 8'd100) begin
        lead = 2'd2;
      end else if (load_word[7:0] >= 8'd10) begin
        lead = 2'd1;
      end else begin
        lead = 2'd0;
      end
    end
  end

endmodule

FILE: hdl/ia2t_zrun_scan.sv
// Zero-run scanner: one IPv6 word per cycle while en is high; keeps the first
// longest run of zero words. Uses ia2t_pkg for the result struct.
module ia2t_zrun_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 en,
  input  logic                 is_zero,
  input  logic [2:0]           idx,
  output ia2t_pkg::zrun_t      best
);
  import ia2t_pkg::*;

  logic [3:0] run_len;
  logic [2:0] run_start;
  logic [3:0] run_len_next;
  logic [2:0] run_start_next;

  always_comb begin
    run_len_next   = run_len + 4'd1;
    run_start_next = (run_len == 4'd0) ? idx : run_start;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      run_len      <= 4'd0;
      run_start    <= 3'd0;
      best.has_run <= 1'b0;
      best.start   <= 3'd0;
      best.len     <= 4'd0;
    end else if (en) begin
      if (is_zero) begin
        run_len   <= run_len_next;
        run_start <= run_start_next;
        if (run_len_next > best.len) begin
          best.has_run <= 1'b1;
          best.start   <= run_start_next;
          best.len     <= run_len_next;
        end
      end else begin
        run_len <= 4'd0;
      end
    end
  end

endmodule

FILE: hdl/ip_address_to_text.sv
// Top level of the address-to-text block: sequencer, address store and
// output register. Uses ia2t_pkg, ia2t_digit_unit and ia2t_zrun_scan.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  command  | start / busy               | cmd, addr_hi, addr_lo, buffer_len
//  result   | result_valid (strobe only) | char_code, status, last
//
// A transaction on the command channel completes at a rising edge with start
// high and busy low. An error transaction passes through the error state;
// IPv4 passes through a setup step and then its characters; IPv6 first
// scans its eight words in turn for the zero run, then passes through a
// setup step and then its characters. Characters follow back to back, and
// each appears in the cycle after the sequencer produces it, from the output
// register. The receiver cannot stall; busy falls as the last result is
// being registered. Reset is synchronous and returns the sequencer to idle.
module ip_address_to_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [63:0] addr_hi,
  input  logic [63:0] addr_lo,
  input  logic [7:0]  buffer_len,
  output logic        result_valid,
  output logic [6:0]  char_code,
  output logic [1:0]  status,
  output logic        last
);
  import ia2t_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_SCAN,
    S_SETUP,
    S_DIG,
    S_SEP,
    S_RUN,
    S_TAIL
  } state_t;

  state_t      state, state_next;
  logic [127:0] addr;
  logic        is_v6;
  logic [1:0]  err_code, err_code_next;
  logic [2:0]  widx, widx_next;
  logic [15:0] word, word_next;
  logic [1:0]  dpos, dpos_next;

  logic        valid_next;
  logic [6:0]  char_next;
  logic [1:0]  status_next;
  logic        last_next;

  logic        accept;
  logic [15:0] cur_word;
  logic [6:0]  dig_ch;
  logic [1:0]  lead;
  zrun_t       zr;
  logic [3:0]  after_word;
  logic [3:0]  after_run;
  logic [3:0]  nwords;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // The current word: a 16-bit IPv6 word, or one IPv4 octet zero-extended.
  always_comb begin
    if (is_v6) begin
      cur_word = addr[{~widx, 4'b0000} +: 16];
    end else begin
      cur_word = {8'd0, addr[{~widx[1:0], 3'b000} +: 8]};
    end
  end

  ia2t_digit_unit u_digit (
    .is_hex    (is_v6),
    .load_word (cur_word),
    .word      (word),
    .dpos      (dpos),
    .ch        (dig_ch),
    .lead      (lead)
  );

  ia2t_zrun_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .clear   (accept),
    .en      (state == S_SCAN),
    .is_zero (cur_word == 16'd0),
    .idx     (widx),
    .best    (zr)
  );

  assign after_word = {1'b0, widx} + 4'd1;
  assign after_run  = {1'b0, widx} + zr.len;
  assign nwords     = is_v6 ? 4'd8 : 4'd4;

  always_comb begin
    state_next    = state;
    err_code_next = err_code;
    widx_next     = widx;
    word_next     = word;
    dpos_next     = dpos;
    valid_next    = 1'b0;
    char_next     = CH_NONE;
    status_next   = ST_OK;
    last_next     = 1'b0;

    unique case (state)
      S_IDLE: begin
        widx_next = 3'd0;
        if (start) begin
          priority if (cmd == FAM_IPV4) begin
            if (buffer_len < IPV4_MIN_BUF) begin
              err_code_next = ST_SMALL;
              state_next    = S_ERR;
            end else begin
              state_next = S_SETUP;
            end
          end else if (cmd == FAM_IPV6) begin
            if (buffer_len < IPV6_MIN_BUF) begin
              err_code_next = ST_SMALL;
              state_next    = S_ERR;
            end else begin
              state_next = S_SCAN;
            end
          end else begin
            err_code_next = ST_FAMILY;
            state_next    = S_ERR;
          end
        end
      end
      S_ERR: begin
        valid_next  = 1'b1;
        status_next = err_code;
        last_next   = 1'b1;
        state_next  = S_IDLE;
      end
      S_SCAN: begin
        // The index wraps back to word zero after the eighth word.
        widx_next = widx + 3'd1;
        if (widx == 3'd7) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        // A leading zero run starts with a colon instead of digits.
        if (is_v6 && zr.has_run && zr.start == 3'd0) begin
          state_next = S_RUN;
        end else begin
          word_next  = cur_word;
          dpos_next  = lead;
          state_next = S_DIG;
        end
      end
      S_DIG: begin
        valid_next = 1'b1;
        char_next  = dig_ch;
        if (dpos != 2'd0) begin
          dpos_next = dpos - 2'd1;
        end else begin
          widx_next = after_word[2:0];
          if (after_word == nwords) begin
            last_next  = 1'b1;
            state_next = S_IDLE;
          end else if (is_v6 && zr.has_run && after_word[2:0] == zr.start) begin
            state_next = S_RUN;
          end else begin
            state_next = S_SEP;
          end
        end
      end
      S_SEP: begin
        valid_next = 1'b1;
        char_next  = is_v6 ? CH_COLON : CH_DOT;
        word_next  = cur_word;
        dpos_next  = lead;
        state_next = S_DIG;
      end
      S_RUN: begin
        // First colon of the compressed run; a run reaching the end adds
        // the closing colon, otherwise the next word follows its separator.
        valid_next = 1'b1;
        char_next  = CH_COLON;
        widx_next  = after_run[2:0];
        state_next = after_run[3] ? S_TAIL : S_SEP;
      end
      S_TAIL: begin
        valid_next = 1'b1;
        char_next  = CH_COLON;
        last_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      widx         <= 3'd0;
      dpos         <= 2'd0;
      err_code     <= ST_OK;
      result_valid <= 1'b0;
      char_code    <= CH_NONE;
      status       <= ST_OK;
      last         <= 1'b0;
    end else begin
      state        <= state_next;
      widx         <= widx_next;
      dpos         <= dpos_next;
      err_code     <= err_code_next;
      result_valid <= valid_next;
      char_code    <= char_next;
      status       <= status_next;
      last         <= last_next;
    end
  end

  // Address payload is captured on acceptance and needs no reset.
  always_ff @(posedge clk) begin
    word <= word_next;
    if (accept) begin
      addr  <= {addr_hi, addr_lo};
      is_v6 <= (cmd == FAM_IPV6);
    end
  end

endmodule

FILE: hdl/ia2t_checker.sv
// Port-level checker for the address-to-text block, bound to the top level.
// Uses ia2t_pkg for status codes and assert_macros.svh for the assertions.
`include "assert_macros.svh"

module ia2t_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [6:0]  char_code,
  input logic [1:0]  status,
  input logic        last
);
  import ia2t_pkg::*;

  // An error result is a single transaction with a zero character.
  `ASSERT_SAME(a_err_single, clk, rst, result_valid && status != ST_OK, last && char_code == CH_NONE, "error result not single")
  // An accepted command keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy did not rise after accept")
  // Characters of one text follow in consecutive cycles.
  `ASSERT_NEXT(a_no_gap, clk, rst, result_valid && !last, result_valid, "gap inside a text")
  // The final result is not followed directly by another one.
  `ASSERT_NEXT(a_last_gap, clk, rst, result_valid && last, !result_valid, "result right after last")

endmodule

bind ip_address_to_text ia2t_checker u_ia2t_checker (.*);

FILE: sim/ip_address_to_text_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ip_address_to_text: a directed table, then random
// address transactions, checked character by character. Depends on ia2t_pkg.
module ip_address_to_text_tb;
  import ia2t_pkg::*;

  // The package names only the two supported families; the other two codes
  // must be rejected with an unsupported-family error.
  localparam logic [1:0] FAM_RSVD2 = 2'd2;
  localparam logic [1:0] FAM_RSVD3 = 2'd3;

  // Cycles with no transaction on either channel before the run is abandoned.
  // The slowest correct item (scan of eight words, setup, 39 characters) plus
  // the longest plausible sender gap stays far below this.
  localparam int STALL_LIMIT = 1000;
  // Drain time after the last expected character; covers a full IPv6 item.
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 42;
  localparam int MAX_REPORTS = 10;

  // How a directed row gets its expected text.
  typedef enum logic [1:0] {
    TEXT_BY_MODEL,
    TEXT_TYPED,
    ERROR_TYPED
  } row_check_t;

  typedef struct {
    row_check_t check;
    logic [1:0] cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0] len;
    string text;
    logic [1:0] err;
  } stim_row_t;

  // One character transaction as the result channel shows it.
  typedef struct packed {
    logic [6:0] code;
    logic [1:0] st;
    logic       lst;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = FAM_IPV4;
  logic [63:0] addr_hi = '0;
  logic [63:0] addr_lo = '0;
  logic [7:0]  buffer_len = '0;
  logic        result_valid;
  logic [6:0]  char_code;
  logic [1:0]  status;
  logic        last;

  // Characters still owed by the block, oldest first, across all items.
  text_char_t pending_chars[$];
  // Scratch text of the item being predicted, before it is committed.
  logic [6:0] text_chars[$];
  stim_row_t  directed_rows[$];

  int fail_count = 0;
  int sender_idle_pct = 0;
  int stall_cycles = 0;

  ip_address_to_text i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .addr_hi      (addr_hi),
    .addr_lo      (addr_lo),
    .buffer_len   (buffer_len),
    .result_valid (result_valid),
    .char_code    (char_code),
    .status       (status),
    .last         (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // Moves the scratch text into the expectation queue; the final character
  // carries the last marker.
  function automatic void commit_text();
    for (int i = 0; i < text_chars.size(); i++) begin
      pending_chars.push_back(text_char_t'{text_chars[i], ST_OK,
                                           i == text_chars.size() - 1});
    end
    text_chars.delete();
  endfunction

  // An error is a single transaction with a null character and last set.
  function automatic void queue_error(input logic [1:0] code);
    pending_chars.push_back(text_char_t'{CH_NONE, code, 1'b1});
  endfunction

  function automatic void queue_literal(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_chars.push_back(7'(s[i]));
    end
    commit_text();
  endfunction

  // Predicts the presentation text of one address transaction and appends
  // it to the expectation queue.
  function automatic void render_address(input logic [1:0] fam, input logic [63:0] hi,
                                         input logic [63:0] lo, input logic [7:0] len);
    logic [7:0]  octet;
    logic [15:0] words[8];
    logic [3:0]  nib;
    int best_start;
    int best_len;
    int run_start;
    int run_len;
    int w;
    bit started;

    best_start = -1;
    best_len = 0;
    run_start = -1;
    run_len = 0;
    text_chars.delete();
    if (fam == FAM_IPV4) begin
      if (len < IPV4_MIN_BUF) begin
        queue_error(ST_SMALL);
        return;
      end
      // Only the low 32 bits of addr_lo matter; first octet is most significant.
      for (int i = 0; i < 4; i++) begin
        if (i > 0) begin
          text_chars.push_back(CH_DOT);
        end
        octet = lo[31 - 8 * i -: 8];
        if (octet >= 100) begin
          text_chars.push_back(CH_ZERO + 7'(octet / 100));
        end
        if (octet >= 10) begin
          text_chars.push_back(CH_ZERO + 7'((octet / 10) % 10));
        end
        text_chars.push_back(CH_ZERO + 7'(octet % 10));
      end
    end else if (fam == FAM_IPV6) begin
      if (len < IPV6_MIN_BUF) begin
        queue_error(ST_SMALL);
        return;
      end
      for (int i = 0; i < 4; i++) begin
        words[i] = hi[63 - 16 * i -: 16];
        words[i + 4] = lo[63 - 16 * i -: 16];
      end
      // Longest zero run; a strictly longer run is needed to replace an
      // earlier one, so the first run wins a tie.
      for (int i = 0; i < 8; i++) begin
        if (words[i] == 16'h0) begin
          if (run_len == 0) begin
            run_start = i;
          end
          run_len++;
          if (run_len > best_len) begin
            best_len = run_len;
            best_start = run_start;
          end
        end else begin
          run_len = 0;
        end
      end
      w = 0;
      while (w < 8) begin
        if (w == best_start) begin
          // The run collapses to "::"; the second colon comes from the next
          // word's separator, or is written here when the run reaches the end.
          text_chars.push_back(CH_COLON);
          w += best_len;
          if (w >= 8) begin
            text_chars.push_back(CH_COLON);
          end
        end else begin
          if (w > 0) begin
            text_chars.push_back(CH_COLON);
          end
          started = 1'b0;
          for (int sh = 12; sh >= 0; sh -= 4) begin
            nib = words[w][sh +: 4];
            if (nib != 4'h0 || started || sh == 0) begin
              text_chars.push_back(nib < 10 ? CH_ZERO + 7'(nib) : CH_HEXA + 7'(nib));
              started = 1'b1;
            end
          end
          w++;
        end
      end
    end else begin
      queue_error(ST_FAMILY);
      return;
    end
    commit_text();
  endfunction

  // Presents one command and holds it until the block takes it. Random idle
  // cycles ahead of the command model a sender with gaps.
  task automatic issue_address(input logic [1:0] fam, input logic [63:0] hi,
                               input logic [63:0] lo, input logic [7:0] len);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= fam;
    addr_hi <= hi;
    addr_lo <= lo;
    buffer_len <= len;
    do @(posedge clk); while (busy);
  endtask

  // IPv6 words lean toward zero so that runs of every length and position
  // appear, and toward short values so that leading-zero suppression is hit.
  function automatic logic [15:0] random_word();
    case ($urandom_range(4))
      0, 1: random_word = 16'h0;
      2: random_word = 16'($urandom_range(15));
      3: random_word = 16'($urandom_range(255));
      default: random_word = 16'($urandom());
    endcase
  endfunction

  // Octets spread over one, two and three decimal digits.
  function automatic logic [7:0] random_octet();
    case ($urandom_range(2))
      0: random_octet = 8'($urandom_range(9));
      1: random_octet = 8'($urandom_range(99, 10));
      default: random_octet = 8'($urandom_range(255, 100));
    endcase
  endfunction

  // Result channel: every strobe is a transaction and must match the oldest
  // expected character field by field.
  always @(posedge clk) begin : check_results
    text_char_t want;
    if (!rst && result_valid) begin
      if (pending_chars.size() == 0) begin
        note_failure($sformatf("unexpected character: code %h status %0d last %0b",
                               char_code, status, last));
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code || status !== want.st || last !== want.lst) begin
          note_failure($sformatf(
            "mismatch: expected code %h status %0d last %0b, got code %h status %0d last %0b",
            want.code, want.st, want.lst, char_code, status, last));
        end
      end
    end
  end

  // Watchdog: any transaction on either channel resets the stall count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [1:0]  fam;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  len;
    logic [7:0]  min_len;
    int pick;

    // Directed rows: extremes of each field, both buffer limits, both
    // unsupported family codes, and the zero-run corner cases (all zero,
    // leading, trailing, single word, tie, later longer run).
    directed_rows = '{
      '{TEXT_TYPED, FAM_IPV4, 64'h0, 64'h0, 8'd16, "0.0.0.0", ST_OK},
      '{TEXT_TYPED, FAM_IPV4, 64'h0, 64'h0000_0000_ffff_ffff, 8'd255,
        "255.255.255.255", ST_OK},
      '{ERROR_TYPED, FAM_IPV4, 64'h0, 64'h0000_0000_0a00_0001, 8'd15, "", ST_SMALL},
      '{ERROR_TYPED, FAM_IPV4, 64'h0, 64'h0, 8'd0, "", ST_SMALL},
      '{TEXT_BY_MODEL, FAM_IPV4, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_0a00_0001, 8'd16,
        "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV4, 64'h0, 64'h0000_0000_0963_64ff, 8'd40, "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV4, 64'h1234_5678_9abc_def0, 64'h5a5a_a5a5_c0a8_0164, 8'd128,
        "", ST_OK},
      '{TEXT_TYPED, FAM_IPV6, 64'h0, 64'h0, 8'd46, "::", ST_OK},
      '{TEXT_TYPED, FAM_IPV6, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'd255,
        "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff", ST_OK},
      '{ERROR_TYPED, FAM_IPV6, 64'hffff_ffff_ffff_ffff, 64'h1, 8'd45, "", ST_SMALL},
      '{ERROR_TYPED, FAM_IPV6, 64'h0, 64'h0, 8'd0, "", ST_SMALL},
      '{ERROR_TYPED, FAM_RSVD2, 64'h0, 64'h0, 8'd0, "", ST_FAMILY},
      '{ERROR_TYPED, FAM_RSVD3, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'd255,
        "", ST_FAMILY},
      '{ERROR_TYPED, FAM_RSVD2, 64'h0, 64'h1, 8'd100, "", ST_FAMILY},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0, 64'h1, 8'd46, "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0001_0000_0000_0000, 64'h0, 8'd200, "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007, 8'd46,
        "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004, 8'd46,
        "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0001_0000_0002_0000, 64'h0000_0000_0003_0004, 8'd46,
        "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0001_0002_0003_0004, 64'h0005_0006_0000_0000, 8'd46,
        "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0000, 8'd46,
        "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0abc_00d0_000f_1000, 64'h1234_5678_9abc_def0, 8'd46,
        "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'h0000_0000_0000_0001, 64'h0002_0000_0000_0000, 8'd255,
        "", ST_OK},
      '{TEXT_BY_MODEL, FAM_IPV6, 64'hfe80_0000_0000_0000, 64'h0200_5eff_fe00_53a0, 8'd64,
        "", ST_OK}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 9;
    foreach (directed_rows[i]) begin
      case (directed_rows[i].check)
        TEXT_TYPED: queue_literal(directed_rows[i].text);
        ERROR_TYPED: queue_error(directed_rows[i].err);
        default: render_address(directed_rows[i].cmd, directed_rows[i].hi,
                                directed_rows[i].lo, directed_rows[i].len);
      endcase
      issue_address(directed_rows[i].cmd, directed_rows[i].hi, directed_rows[i].lo,
                    directed_rows[i].len);
    end

    // Random part in three phases: a sender with light gaps, one with heavy
    // gaps, and one that keeps start high back to back.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 56 : 0;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          fam = FAM_IPV4;
        end else if (pick < 90) begin
          fam = FAM_IPV6;
        end else begin
          fam = ($urandom_range(1) == 0) ? FAM_RSVD2 : FAM_RSVD3;
        end
        if (fam == FAM_IPV4) begin
          // Upper bits are don't-care for IPv4; fill them half the time.
          hi = ($urandom_range(1) == 0) ? 64'h0 : {$urandom(), $urandom()};
          lo[63:32] = ($urandom_range(1) == 0) ? 32'h0 : 32'($urandom());
          lo[31:0] = {random_octet(), random_octet(), random_octet(), random_octet()};
        end else if (fam == FAM_IPV6) begin
          hi = {random_word(), random_word(), random_word(), random_word()};
          lo = {random_word(), random_word(), random_word(), random_word()};
        end else begin
          hi = {$urandom(), $urandom()};
          lo = {$urandom(), $urandom()};
        end
        // Mostly a buffer that is large enough; one in ten is anything at all.
        min_len = (fam == FAM_IPV6) ? IPV6_MIN_BUF : IPV4_MIN_BUF;
        if ($urandom_range(9) == 0) begin
          len = 8'($urandom_range(255));
        end else begin
          len = 8'($urandom_range(255, int'(min_len)));
        end
        render_address(fam, hi, lo, len);
        issue_address(fam, hi, lo, len);
      end
    end
    start <= 1'b0;

    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    // Any character that shows up after this point is unexpected.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: ip_address_to_text.f
+incdir+hdl
hdl/ia2t_pkg.sv
hdl/ia2t_digit_unit.sv
hdl/ia2t_zrun_scan.sv
hdl/ip_address_to_text.sv
hdl/ia2t_checker.sv
sim/ip_address_to_text_tb.sv
